@@ design/mtcd_pkg.sv @@
package mtcd_pkg;

    localparam int CUR_W       = 15;
    localparam int SUM_W       = 33;
    localparam int CNT_W       = 3;
    localparam int TOT_W       = 35;
    localparam int DVD_W       = 36;
    localparam int DIG_W       = 18;
    localparam int DIV_STEPS   = 2;
    localparam int RECIP_SH    = 28;
    localparam int QUO_W       = 31;
    localparam int PROD_W      = 32;
    localparam int RAD_W       = 32;
    localparam int ROOT_W      = 16;
    localparam int SREM_W      = 18;
    localparam int SQ_STEPS    = 16;
    localparam int STEP_W      = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COMP_ENABLE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATOR_SETPOINT = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_S,
        ST_SQ_T,
        ST_ADD_T,
        ST_TOTAL,
        ST_DIV,
        ST_RAD1,
        ST_SQRT1,
        ST_MUL_IS,
        ST_MUL_IQ,
        ST_RAD2,
        ST_SQRT2,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_R,
        MUL_S,
        MUL_T,
        MUL_DSQ,
        MUL_IS,
        MUL_IQ
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_R,
        ACC_S,
        ACC_T
    } t_acc_sel;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        t_acc_sel acc_sel;
        logic     div_load;
        logic     div_step;
        logic     rad1_load;
        logic     rad_save;
        logic     rad2_load;
        logic     sqrt_step;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        logic in_ok;
        logic cnt_full;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/motor_thermal_comp_dac_top.sv @@
// Thermal compensation DAC for a three-phase motor. Each input transaction
// carries the RMS currents of phases R, S and T (unsigned Q0.15) and a read-ok
// flag. With comp_enable set, good samples are squared and summed; every
// SAMPLES_PER_UPDATE good samples the window mean square gives
// iq = sqrt(2/3*mean - id^2) and then id = sqrt(is^2 - iq^2) (zero where the
// radicand is negative), and one result with DAC code floor(id*32767/32768)
// is sent. A failed read clears id and the window and sends code 0 with the
// read_failed flag. With comp_enable clear, transactions are taken and dropped.
// One item is worked on at a time. A failed read and a window-closing sample
// wait for the output register to be free; a window-closing sample spends most
// of its time in two 16-step square roots, and the divide by
// 3*SAMPLES_PER_UPDATE is done by reciprocal multiplication on 18-bit digits.
// Configuration writes are always taken and must be made while idle.
module motor_thermal_comp_dac_top #(
    parameter int SAMPLES_PER_UPDATE = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtcd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // phase_r_rms [14:0], phase_s_rms [29:15], phase_t_rms [44:30], zero [47:45]
    input  logic [mtcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // read_ok [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dac_value [14:0], zero [15]
    output logic [mtcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // read_failed [0]
    output logic                                m_axis_tuser
);
    import mtcd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mtcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mtcd_dp #(
        .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

@@ design/mtcd_ctrl.sv @@
module mtcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  mtcd_pkg::t_dp_sts i_sts,
    output mtcd_pkg::t_dp_cmd o_cmd
);
    import mtcd_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.acc_sel = ACC_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    priority if (!i_sts.enable) begin
                        n_state = ST_IDLE;
                    end else if (!i_sts.in_ok) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SQ_R;
                    end
                end
            end
            ST_SQ_R: begin
                o_cmd.mul_sel = MUL_R;
                n_state = ST_SQ_S;
            end
            ST_SQ_S: begin
                o_cmd.acc_sel = ACC_R;
                o_cmd.mul_sel = MUL_S;
                n_state = ST_SQ_T;
            end
            ST_SQ_T: begin
                o_cmd.acc_sel = ACC_S;
                o_cmd.mul_sel = MUL_T;
                n_state = ST_ADD_T;
            end
            ST_ADD_T: begin
                o_cmd.acc_sel = ACC_T;
                n_state = i_sts.cnt_full ? ST_TOTAL : ST_IDLE;
            end
            ST_TOTAL: begin
                o_cmd.div_load = 1'b1;
                o_cmd.mul_sel  = MUL_DSQ;
                n_step  = STEP_W'(DIV_STEPS - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_RAD1;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_RAD1: begin
                o_cmd.rad1_load = 1'b1;
                n_step  = STEP_W'(SQ_STEPS - 1);
                n_state = ST_SQRT1;
            end
            ST_SQRT1: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_MUL_IS;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_MUL_IS: begin
                o_cmd.mul_sel = MUL_IS;
                n_state = ST_MUL_IQ;
            end
            ST_MUL_IQ: begin
                o_cmd.rad_save = 1'b1;
                o_cmd.mul_sel  = MUL_IQ;
                n_state = ST_RAD2;
            end
            ST_RAD2: begin
                o_cmd.rad2_load = 1'b1;
                n_step  = STEP_W'(SQ_STEPS - 1);
                n_state = ST_SQRT2;
            end
            ST_SQRT2: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/mtcd_dp.sv @@
module mtcd_dp #(
    parameter int SAMPLES_PER_UPDATE = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtcd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [mtcd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mtcd_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tuser,
    input  mtcd_pkg::t_dp_cmd                   i_cmd,
    output mtcd_pkg::t_dp_sts                   o_sts
);
    import mtcd_pkg::*;

    localparam int DIVISOR = 3 * SAMPLES_PER_UPDATE;
    localparam int DIV_W   = $clog2(DIVISOR + 1);
    localparam int DNUM_W  = DIV_W + DIG_W;
    localparam int DPROD_W = DNUM_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP_M  =
        RECIP_SH'((2**RECIP_SH + DIVISOR - 1) / DIVISOR);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(SAMPLES_PER_UPDATE - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(SAMPLES_PER_UPDATE);

    logic                  r_enable;
    logic [CUR_W-1:0]      r_setpoint;
    logic [CUR_W-1:0]      r_in_r, r_in_s, r_in_t;
    logic                  r_fail;
    logic [SUM_W-1:0]      r_sum_r, r_sum_s, r_sum_t;
    logic [CNT_W-1:0]      r_cnt;
    logic [CUR_W-1:0]      r_d;
    logic [PROD_W-1:0]     r_prod;
    logic [DVD_W-1:0]      r_dvd;
    logic [DIV_W-1:0]      r_drem;
    logic [RAD_W-1:0]      r_rad;
    logic [SREM_W-1:0]     r_srem;
    logic [ROOT_W-1:0]     r_root;
    logic                  r_ovalid;
    logic [CUR_W-1:0]      r_odata;
    logic                  r_ofail;

    logic [ROOT_W-1:0]     w_mul_a;
    logic [PROD_W-1:0]     w_prod;
    logic [TOT_W-1:0]      w_total;
    logic [DNUM_W-1:0]     w_dnum;
    logic [DPROD_W-1:0]    w_dprod;
    logic [DIG_W-1:0]      w_dq;
    logic [DNUM_W-1:0]     w_dqk;
    logic [DIV_W-1:0]      w_drem;
    logic [QUO_W-1:0]      w_quo;
    logic [QUO_W-1:0]      w_dsq;
    logic [QUO_W-1:0]      w_rad1;
    logic [RAD_W-1:0]      w_rad2;
    logic [SREM_W+1:0]     w_strial;
    logic [SREM_W+1:0]     w_stry;
    logic [SREM_W+1:0]     w_sdiff;
    logic                  w_sge;
    logic [CUR_W-1:0]      w_id;
    logic [CUR_W-1:0]      w_dac;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_NONE: w_mul_a = '0;
            MUL_R:    w_mul_a = {1'b0, r_in_r};
            MUL_S:    w_mul_a = {1'b0, r_in_s};
            MUL_T:    w_mul_a = {1'b0, r_in_t};
            MUL_DSQ:  w_mul_a = {1'b0, r_d};
            MUL_IS:   w_mul_a = {1'b0, r_setpoint};
            MUL_IQ:   w_mul_a = r_root;
            default:  w_mul_a = '0;
        endcase
    end

    assign w_prod   = PROD_W'(w_mul_a) * PROD_W'(w_mul_a);
    assign w_total  = {2'b00, r_sum_r} + {2'b00, r_sum_s} + {2'b00, r_sum_t};

    // divide one 18-bit digit per cycle by reciprocal multiplication
    assign w_dnum   = {r_drem, r_dvd[DVD_W-1 -: DIG_W]};
    assign w_dprod  = DPROD_W'(w_dnum) * DPROD_W'(RECIP_M);
    assign w_dq     = w_dprod[RECIP_SH +: DIG_W];
    assign w_dqk    = DNUM_W'(w_dq) * DNUM_W'(DIVISOR);
    assign w_drem   = DIV_W'(w_dnum - w_dqk);

    assign w_quo    = r_dvd[QUO_W-1:0];
    assign w_dsq    = r_prod[QUO_W-1:0];
    assign w_rad1   = (w_quo >= w_dsq) ? (w_quo - w_dsq) : '0;
    assign w_rad2   = (r_rad >= r_prod) ? (r_rad - r_prod) : '0;

    assign w_strial = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_stry   = {2'b00, r_root, 2'b01};
    assign w_sge    = (w_strial >= w_stry);
    assign w_sdiff  = w_strial - w_stry;

    assign w_id     = r_root[CUR_W-1:0];
    assign w_dac    = (w_id == '0) ? '0 : (w_id - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_setpoint <= '0;
            r_sum_r    <= '0;
            r_sum_s    <= '0;
            r_sum_t    <= '0;
            r_cnt      <= '0;
            r_d        <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COMP_ENABLE:     r_enable   <= i_cfg_data[0];
                    CFG_STATOR_SETPOINT: r_setpoint <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_cmd.acc_sel)
                ACC_R: r_sum_r <= r_sum_r + {1'b0, r_prod};
                ACC_S: r_sum_s <= r_sum_s + {1'b0, r_prod};
                ACC_T: begin
                    r_sum_t <= r_sum_t + {1'b0, r_prod};
                    r_cnt   <= r_cnt + 1'b1;
                end
                default: ;
            endcase
            if (i_cmd.emit) begin
                r_sum_r  <= '0;
                r_sum_s  <= '0;
                r_sum_t  <= '0;
                r_cnt    <= '0;
                r_d      <= r_fail ? '0 : w_id;
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_r <= i_s_tdata[CUR_W-1:0];
            r_in_s <= i_s_tdata[2*CUR_W-1:CUR_W];
            r_in_t <= i_s_tdata[3*CUR_W-1:2*CUR_W];
            r_fail <= !i_s_tuser;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_load) begin
            r_dvd  <= {w_total, 1'b0};
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DVD_W-DIG_W-1:0], w_dq};
            r_drem <= w_drem;
        end
        if (i_cmd.rad1_load) begin
            r_rad  <= {1'b0, w_rad1};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.rad_save) begin
            r_rad  <= r_prod;
        end else if (i_cmd.rad2_load) begin
            r_rad  <= w_rad2;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_srem <= w_sge ? w_sdiff[SREM_W-1:0] : w_strial[SREM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_sge};
        end
        if (i_cmd.emit) begin
            r_odata <= r_fail ? '0 : w_dac;
            r_ofail <= r_fail;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_odata};
    assign o_m_tuser  = r_ofail;

    assign o_sts.enable   = r_enable;
    assign o_sts.in_ok    = i_s_tuser;
    assign o_sts.cnt_full = (r_cnt == CNT_LAST);
    assign o_sts.out_free = !r_ovalid || i_m_tready;

    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.emit))
        else $error("output valid rose without an emit");

    a_window_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> (r_cnt == CNT_FULL))
        else $error("window closed with a wrong sample count");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_cnt == '0) && (r_sum_r == '0) && (r_sum_t == '0))
        else $error("window not cleared after emit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofail) |-> (r_odata == '0))
        else $error("failed-read transaction carries a nonzero code");

endmodule

@@ dv/mtcd_checker.sv @@
`timescale 1ns / 1ps

module mtcd_checker #(
    parameter int SAMPLES_PER_UPDATE = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [mtcd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [mtcd_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                                i_in_user,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [mtcd_pkg::OUT_TDATA_W-1:0]    i_out_data,
    input  logic                                i_out_user,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import mtcd_pkg::*;

    typedef struct packed {
        logic [CUR_W-1:0] dac_value;
        logic             read_failed;
    } t_dac_result;

    logic             comp_on;
    logic [CUR_W-1:0] setpoint;
    logic [SUM_W-1:0] acc_r;
    logic [SUM_W-1:0] acc_s;
    logic [SUM_W-1:0] acc_t;
    logic [CNT_W-1:0] win_count;
    logic [CUR_W-1:0] id_cur;
    t_dac_result      pending_dac[$];

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic clear_window();
        acc_r     = '0;
        acc_s     = '0;
        acc_t     = '0;
        win_count = '0;
    endtask

    task automatic step_compensation(logic [IN_TDATA_W-1:0] data, logic ok);
        longint unsigned r, s, t, total, two_thirds, dsq, iq, is_sq, iq_sq;
        t_dac_result     res;
        if (!comp_on)
            return;
        if (!ok) begin
            id_cur = '0;
            clear_window();
            res.dac_value   = '0;
            res.read_failed = 1'b1;
            pending_dac.push_back(res);
            return;
        end
        r = data[CUR_W-1:0];
        s = data[2*CUR_W-1:CUR_W];
        t = data[3*CUR_W-1:2*CUR_W];
        acc_r     = SUM_W'(acc_r + r * r);
        acc_s     = SUM_W'(acc_s + s * s);
        acc_t     = SUM_W'(acc_t + t * t);
        win_count = win_count + 1'b1;
        if (win_count < SAMPLES_PER_UPDATE)
            return;
        total      = longint'(acc_r) + acc_s + acc_t;
        two_thirds = (2 * total) / (3 * SAMPLES_PER_UPDATE);
        dsq        = longint'(id_cur) * id_cur;
        iq         = (two_thirds >= dsq) ? floor_sqrt(two_thirds - dsq) : 0;
        is_sq      = longint'(setpoint) * setpoint;
        iq_sq      = iq * iq;
        id_cur     = (is_sq >= iq_sq) ? CUR_W'(floor_sqrt(is_sq - iq_sq)) : '0;
        clear_window();
        res.dac_value   = CUR_W'((longint'(id_cur) * 32767) >> 15);
        res.read_failed = 1'b0;
        pending_dac.push_back(res);
    endtask

    task automatic check_result(logic [CUR_W-1:0] dac, logic failed);
        t_dac_result want;
        if (pending_dac.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected result dac_value=%0d read_failed=%0d",
                         $realtime, dac, failed);
            return;
        end
        want = pending_dac.pop_front();
        if (want.dac_value !== dac || want.read_failed !== failed) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: mismatch dac_value exp=%0d act=%0d, read_failed exp=%0d act=%0d",
                         $realtime, want.dac_value, dac, want.read_failed, failed);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            comp_on  = 1'b0;
            setpoint = '0;
            id_cur   = '0;
            clear_window();
            pending_dac.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COMP_ENABLE:     comp_on = i_cfg_data[0];
                    CFG_STATOR_SETPOINT: setpoint = i_cfg_data[CUR_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                check_result(i_out_data[CUR_W-1:0], i_out_user);
            if (i_in_valid && i_in_ready)
                step_compensation(i_in_data, i_in_user);
        end
        o_pending = pending_dac.size();
    end

endmodule

@@ dv/tb_motor_thermal_comp_dac_top.sv @@
`timescale 1ns / 1ps

module tb_motor_thermal_comp_dac_top;
    import mtcd_pkg::*;

    localparam int WINDOW      = 5;
    localparam int SETTLE      = 120;
    localparam int TARGET_ITEM = 1000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    int                      fail_count;
    int                      pending;
    bit                      no_idle = 1'b0;
    int unsigned             rx_hold = 0;
    int                      items_sent = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    motor_thermal_comp_dac_top #(
        .SAMPLES_PER_UPDATE(WINDOW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mtcd_checker #(
        .SAMPLES_PER_UPDATE(WINDOW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(4, 1);
        return $urandom_range(80, 15);
    endfunction

    function automatic logic [CUR_W-1:0] pick_current(int center);
        int lo;
        int hi;
        lo = (center > 1500) ? center - 1500 : 0;
        hi = (center < 32767 - 1500) ? center + 1500 : 32767;
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return CUR_W'($urandom_range(32767, 0));
            default: return CUR_W'($urandom_range(hi, lo));
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold <= no_idle ? 0 : gap_len();
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_enable(logic en);
        write_reg(CFG_COMP_ENABLE, {(CFG_DATA_W-1)'($urandom), en});
    endtask

    task automatic send_sample(logic [CUR_W-1:0] r, logic [CUR_W-1:0] s,
                               logic [CUR_W-1:0] t, logic ok);
        int unsigned gap;
        gap = no_idle ? 0 : gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {3'b000, t, s, r};
        s_axis_tuser  <= ok;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // hold until every expected transaction has arrived and the block is idle
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase();
        int   n;
        int   center;
        logic en;
        logic [CUR_W-1:0] sp;
        settle_idle();
        no_idle = ($urandom_range(3, 0) == 0);
        en      = ($urandom_range(5, 0) != 0);
        center  = $urandom_range(32767, 0);
        case ($urandom_range(5, 0))
            0:       sp = '0;
            1:       sp = '1;
            2, 3:    sp = CUR_W'($urandom_range(32767, 0));
            default: sp = CUR_W'(center * 4 / 5);
        endcase
        write_reg(CFG_STATOR_SETPOINT, sp);
        set_enable(en);
        n = $urandom_range(70, 30);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4, 0) == 0)
                center = $urandom_range(32767, 0);
            if ($urandom_range(19, 0) == 0)
                send_sample(CUR_W'($urandom), CUR_W'($urandom), CUR_W'($urandom), 1'b0);
            else
                send_sample(pick_current(center), pick_current(center),
                            pick_current(center), 1'b1);
            items_sent++;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // negative second radicand, then full scale, then a zero first radicand
        write_reg(CFG_STATOR_SETPOINT, '0);
        set_enable(1'b1);
        repeat (WINDOW) send_sample('1, '1, '1, 1'b1);
        settle_idle();
        write_reg(CFG_STATOR_SETPOINT, '1);
        repeat (WINDOW) send_sample('1, '1, '1, 1'b1);
        repeat (WINDOW) send_sample('0, '0, '0, 1'b1);

        // failed read in the middle of a window
        send_sample(15'h5555, 15'h2AAA, 15'h7FFF, 1'b1);
        send_sample(15'h2AAA, 15'h5555, 15'h0001, 1'b1);
        send_sample('1, '1, '1, 1'b0);

        // disabling holds a partial window
        send_sample(15'h4000, 15'h1234, 15'h6789, 1'b1);
        send_sample(15'h0FFF, 15'h7000, 15'h3333, 1'b1);
        settle_idle();
        set_enable(1'b0);
        send_sample('1, '1, '1, 1'b1);
        send_sample('1, '1, '1, 1'b0);
        settle_idle();
        write_reg(CFG_STATOR_SETPOINT, 15'd12345);
        set_enable(1'b1);
        send_sample(15'd20000, 15'd18000, 15'd22000, 1'b1);
        send_sample(15'd100, 15'd32000, 15'd7, 1'b1);
        send_sample(15'd16384, 15'd16383, 15'd8192, 1'b1);
        items_sent = 25;

        while (items_sent < TARGET_ITEM)
            random_phase();

        no_idle = 1'b0;
        settle_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mtcd_pkg.sv
design/mtcd_ctrl.sv
design/mtcd_dp.sv
design/motor_thermal_comp_dac_top.sv
dv/mtcd_checker.sv
dv/tb_motor_thermal_comp_dac_top.sv
